/* hdl/fpd_pkg.sv */
// Shared types and constants for the flight phase detector.
package fpd_pkg;

    localparam int TIME_W  = 32;
    localparam int CLIMB_W = 14;
    localparam int SPEED_W = 13;
    localparam int THR_W   = 13;
    localparam int ADDR_W  = 3;
    localparam int CFG_W   = 32;

    typedef enum logic [1:0] {
        PH_GROUND    = 2'd0,
        PH_LAUNCHING = 2'd1,
        PH_IN_FLIGHT = 2'd2,
        PH_LANDING   = 2'd3
    } t_phase;

    typedef enum logic [ADDR_W-1:0] {
        REG_LAUNCH_CLIMB_THR  = 3'd0,
        REG_LAUNCH_SPEED_THR  = 3'd1,
        REG_LAUNCH_HOLD       = 3'd2,
        REG_LANDING_SPEED_THR = 3'd3,
        REG_LANDING_CLIMB_THR = 3'd4,
        REG_LANDING_HOLD      = 3'd5
    } t_reg_idx;

    localparam logic [THR_W-1:0]  RST_LAUNCH_CLIMB_THR  = 13'd50;
    localparam logic [THR_W-1:0]  RST_LAUNCH_SPEED_THR  = 13'd100;
    localparam logic [TIME_W-1:0] RST_LAUNCH_HOLD       = 32'd5000;
    localparam logic [THR_W-1:0]  RST_LANDING_SPEED_THR = 13'd30;
    localparam logic [THR_W-1:0]  RST_LANDING_CLIMB_THR = 13'd30;
    localparam logic [TIME_W-1:0] RST_LANDING_HOLD      = 32'd60000;

    typedef struct packed {
        logic [THR_W-1:0]  launch_climb_threshold;
        logic [THR_W-1:0]  launch_speed_threshold;
        logic [TIME_W-1:0] launch_hold_time;
        logic [THR_W-1:0]  landing_speed_threshold;
        logic [THR_W-1:0]  landing_climb_threshold;
        logic [TIME_W-1:0] landing_hold_time;
    } t_cfg;

    typedef struct packed {
        logic signed [CLIMB_W-1:0] climb_rate;
        logic [SPEED_W-1:0]        ground_speed;
        logic [TIME_W-1:0]         timestamp;
    } t_sample;

    typedef struct packed {
        t_phase            phase;
        logic              phase_changed;
        logic [TIME_W-1:0] phase_entry_time;
        logic [TIME_W-1:0] flight_duration;
    } t_result;

endpackage

/* hdl/fpd_cfg.sv */
// Configuration register file for the flight phase detector.
module fpd_cfg
    import fpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_valid,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output t_cfg              o_cfg
);

    t_cfg r_cfg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cfg.launch_climb_threshold  <= RST_LAUNCH_CLIMB_THR;
            r_cfg.launch_speed_threshold  <= RST_LAUNCH_SPEED_THR;
            r_cfg.launch_hold_time        <= RST_LAUNCH_HOLD;
            r_cfg.landing_speed_threshold <= RST_LANDING_SPEED_THR;
            r_cfg.landing_climb_threshold <= RST_LANDING_CLIMB_THR;
            r_cfg.landing_hold_time       <= RST_LANDING_HOLD;
        end else if (i_cfg_valid) begin
            unique case (i_cfg_addr)
                REG_LAUNCH_CLIMB_THR:  r_cfg.launch_climb_threshold  <= i_cfg_data[THR_W-1:0];
                REG_LAUNCH_SPEED_THR:  r_cfg.launch_speed_threshold  <= i_cfg_data[THR_W-1:0];
                REG_LAUNCH_HOLD:       r_cfg.launch_hold_time        <= i_cfg_data[TIME_W-1:0];
                REG_LANDING_SPEED_THR: r_cfg.landing_speed_threshold <= i_cfg_data[THR_W-1:0];
                REG_LANDING_CLIMB_THR: r_cfg.landing_climb_threshold <= i_cfg_data[THR_W-1:0];
                REG_LANDING_HOLD:      r_cfg.landing_hold_time       <= i_cfg_data[TIME_W-1:0];
                default: ;
            endcase
        end
    end

    assign o_cfg = r_cfg;

endmodule

/* hdl/fpd_core.sv */
// Phase state machine and per-sample result logic.
module fpd_core
    import fpd_pkg::*;
(
    input  logic    i_clk,
    input  logic    i_rst_n,
    input  logic    i_advance,
    input  t_sample i_sample,
    input  t_cfg    i_cfg,
    output t_result o_result
);

    t_phase            r_phase,   n_phase;
    logic              r_launch_q, n_launch_q;
    logic              r_landing_q, n_landing_q;
    logic [TIME_W-1:0] r_cond_start, n_cond_start;
    logic [TIME_W-1:0] r_flight_start, n_flight_start;
    logic [TIME_W-1:0] r_entry, n_entry;

    logic signed [CLIMB_W:0] climb_ext;
    logic [CLIMB_W-1:0]      climb_mag;
    logic                    launch_cond;
    logic                    landing_cond;
    logic [TIME_W-1:0]       now;
    logic [TIME_W-1:0]       held;
    logic                    changed;

    assign now       = i_sample.timestamp;
    assign climb_ext = {i_sample.climb_rate[CLIMB_W-1], i_sample.climb_rate};
    assign climb_mag = climb_ext[CLIMB_W] ? CLIMB_W'(-climb_ext) : climb_ext[CLIMB_W-1:0];

    assign launch_cond =
        (climb_ext > $signed({2'b00, i_cfg.launch_climb_threshold})) ||
        (i_sample.ground_speed > i_cfg.launch_speed_threshold);
    assign landing_cond =
        (i_sample.ground_speed < i_cfg.landing_speed_threshold) &&
        (climb_mag < {1'b0, i_cfg.landing_climb_threshold});

    // qualification and flight start tracking
    always_comb begin
        n_launch_q     = r_launch_q;
        n_landing_q    = r_landing_q;
        n_cond_start   = r_cond_start;
        n_flight_start = r_flight_start;
        unique case (r_phase)
            PH_GROUND: begin
                n_launch_q = launch_cond;
                if (launch_cond && !r_launch_q) begin
                    n_cond_start = now;
                end
            end
            PH_LAUNCHING: begin
                n_flight_start = now;
                n_landing_q    = 1'b0;
            end
            PH_IN_FLIGHT: begin
                n_landing_q = landing_cond;
                if (landing_cond && !r_landing_q) begin
                    n_cond_start = now;
                end
            end
            PH_LANDING: begin
                n_launch_q = 1'b0;
            end
            default: ;
        endcase
    end

    assign held = now - n_cond_start;

    // next phase
    always_comb begin
        n_phase = r_phase;
        unique case (r_phase)
            PH_GROUND: begin
                if (n_launch_q && (held >= i_cfg.launch_hold_time)) begin
                    n_phase = PH_LAUNCHING;
                end
            end
            PH_LAUNCHING: n_phase = PH_IN_FLIGHT;
            PH_IN_FLIGHT: begin
                if (n_landing_q && (held >= i_cfg.landing_hold_time)) begin
                    n_phase = PH_LANDING;
                end
            end
            PH_LANDING:   n_phase = PH_GROUND;
            default:      n_phase = PH_GROUND;
        endcase
    end

    assign changed = (n_phase != r_phase);
    assign n_entry = changed ? now : r_entry;

    // result fields
    always_comb begin
        o_result.phase            = n_phase;
        o_result.phase_changed    = changed;
        o_result.phase_entry_time = n_entry;
        o_result.flight_duration  = '0;
        if ((n_phase == PH_IN_FLIGHT) && (n_flight_start != '0)) begin
            o_result.flight_duration = now - n_flight_start;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase        <= PH_GROUND;
            r_launch_q     <= 1'b0;
            r_landing_q    <= 1'b0;
            r_cond_start   <= '0;
            r_flight_start <= '0;
            r_entry        <= '0;
        end else if (i_advance) begin
            r_phase        <= n_phase;
            r_launch_q     <= n_launch_q;
            r_landing_q    <= n_landing_q;
            r_cond_start   <= n_cond_start;
            r_flight_start <= n_flight_start;
            r_entry        <= n_entry;
        end
    end

endmodule

/* hdl/flight_phase_detector.sv */
// Top level of the flight phase detector: sample register, core, result register.
//
//  channel   | dir | handshake                      | content
//  s_axis    | in  | i_s_axis_tvalid/o_s_axis_tready | sensor sample request
//  m_axis    | out | o_m_axis_tvalid/i_m_axis_tready | phase result request
//  cfg       | in  | i_cfg_valid/o_cfg_ready         | register index and value
//
// One request per clock sustained while the result side is ready; an accepted sample
// passes through the sample register, then the result register, to appear as a result.
// The phase state updates when a sample moves from the sample register into the
// result register. A stalled result holds while one more sample waits.
// Reset is synchronous, active low, and returns the valid flags, phase state and configuration to their defaults.
module flight_phase_detector
    import fpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_axis_tvalid,
    output logic              o_s_axis_tready,
    // [13:0] climb_rate, [26:14] ground_speed, [58:27] timestamp
    input  logic [63:0]       i_s_axis_tdata,
    output logic              o_m_axis_tvalid,
    input  logic              i_m_axis_tready,
    // [1:0] phase, [2] phase_changed, [34:3] phase_entry_time,
    // [66:35] flight_duration
    output logic [71:0]       o_m_axis_tdata,
    input  logic              i_cfg_valid,
    output logic              o_cfg_ready,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_data
);

    t_cfg    cfg;
    t_sample r_sample;
    logic    r_in_valid;
    t_result core_result;
    t_result r_result;
    logic    r_out_valid;
    logic    advance;
    logic    in_fire;

    assign o_cfg_ready = 1'b1;

    fpd_cfg u_cfg (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_cfg       (cfg)
    );

    assign advance         = r_in_valid && (!r_out_valid || i_m_axis_tready);
    assign o_s_axis_tready = !r_in_valid || advance;
    assign in_fire         = i_s_axis_tvalid && o_s_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_fire) begin
            r_in_valid <= 1'b1;
        end else if (advance) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_fire) begin
            r_sample.climb_rate   <= i_s_axis_tdata[13:0];
            r_sample.ground_speed <= i_s_axis_tdata[26:14];
            r_sample.timestamp    <= i_s_axis_tdata[58:27];
        end
    end

    fpd_core u_core (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_advance (advance),
        .i_sample  (r_sample),
        .i_cfg     (cfg),
        .o_result  (core_result)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (advance) begin
            r_out_valid <= 1'b1;
        end else if (i_m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_result <= core_result;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = {5'b0, r_result.flight_duration, r_result.phase_entry_time,
                              r_result.phase_changed, r_result.phase};

endmodule

/* tb/flight_phase_checker.sv */
// Checker for the flight phase detector: tracks the phase machine and compares every result.
module flight_phase_checker
    import fpd_pkg::*;
(
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_s_tvalid,
    input  logic              i_s_tready,
    input  logic [63:0]       i_s_tdata,
    input  logic              i_m_tvalid,
    input  logic              i_m_tready,
    input  logic [71:0]       i_m_tdata,
    input  logic              i_cfg_valid,
    input  logic              i_cfg_ready,
    input  logic [ADDR_W-1:0] i_cfg_addr,
    input  logic [CFG_W-1:0]  i_cfg_data,
    output int                o_errors,
    output int                o_pending
);

    t_cfg              cfg_q;
    t_phase            phase_q;
    logic              launch_armed;
    logic              landing_armed;
    logic [TIME_W-1:0] cond_since;
    logic [TIME_W-1:0] flight_since;
    logic [TIME_W-1:0] phase_since;
    t_result           reports_due[$];
    int                mismatches = 0;

    assign o_errors = mismatches;

    task automatic step_phase_machine(input logic [63:0] word, output t_result res);
        int                climb;
        int                mag;
        logic [SPEED_W-1:0] speed;
        logic [TIME_W-1:0] now;
        logic [TIME_W-1:0] held;
        logic              cond;
        t_phase            next_ph;
        climb = {{(32-CLIMB_W){word[CLIMB_W-1]}}, word[CLIMB_W-1:0]};
        speed = word[CLIMB_W +: SPEED_W];
        now   = word[CLIMB_W+SPEED_W +: TIME_W];
        mag   = (climb < 0) ? -climb : climb;
        next_ph = phase_q;
        res = '0;
        case (phase_q)
            PH_GROUND: begin
                cond = (climb > int'(cfg_q.launch_climb_threshold)) ||
                       (speed > cfg_q.launch_speed_threshold);
                if (cond && !launch_armed) begin
                    launch_armed = 1'b1;
                    cond_since   = now;
                end else if (!cond) begin
                    launch_armed = 1'b0;
                end
                held = now - cond_since;
                if (launch_armed && held >= cfg_q.launch_hold_time) next_ph = PH_LAUNCHING;
            end
            PH_LAUNCHING: begin
                next_ph       = PH_IN_FLIGHT;
                flight_since  = now;
                landing_armed = 1'b0;
            end
            PH_IN_FLIGHT: begin
                cond = (speed < cfg_q.landing_speed_threshold) &&
                       (mag < int'(cfg_q.landing_climb_threshold));
                if (cond && !landing_armed) begin
                    landing_armed = 1'b1;
                    cond_since    = now;
                end else if (!cond) begin
                    landing_armed = 1'b0;
                end
                held = now - cond_since;
                if (landing_armed && held >= cfg_q.landing_hold_time) next_ph = PH_LANDING;
            end
            default: begin
                next_ph      = PH_GROUND;
                launch_armed = 1'b0;
            end
        endcase
        if (next_ph != phase_q) begin
            phase_q           = next_ph;
            phase_since       = now;
            res.phase_changed = 1'b1;
        end
        res.phase            = phase_q;
        res.phase_entry_time = phase_since;
        if (phase_q == PH_IN_FLIGHT && flight_since != '0)
            res.flight_duration = now - flight_since;
    endtask

    always @(posedge i_clk) begin : watch
        t_result want;
        t_result seen;
        if (!i_rst_n) begin
            cfg_q.launch_climb_threshold  = RST_LAUNCH_CLIMB_THR;
            cfg_q.launch_speed_threshold  = RST_LAUNCH_SPEED_THR;
            cfg_q.launch_hold_time        = RST_LAUNCH_HOLD;
            cfg_q.landing_speed_threshold = RST_LANDING_SPEED_THR;
            cfg_q.landing_climb_threshold = RST_LANDING_CLIMB_THR;
            cfg_q.landing_hold_time       = RST_LANDING_HOLD;
            phase_q       = PH_GROUND;
            launch_armed  = 1'b0;
            landing_armed = 1'b0;
            cond_since    = '0;
            flight_since  = '0;
            phase_since   = '0;
            reports_due.delete();
        end else begin
            if (i_cfg_valid && i_cfg_ready) begin
                case (i_cfg_addr)
                    REG_LAUNCH_CLIMB_THR:  cfg_q.launch_climb_threshold  = i_cfg_data[THR_W-1:0];
                    REG_LAUNCH_SPEED_THR:  cfg_q.launch_speed_threshold  = i_cfg_data[THR_W-1:0];
                    REG_LAUNCH_HOLD:       cfg_q.launch_hold_time        = i_cfg_data[TIME_W-1:0];
                    REG_LANDING_SPEED_THR: cfg_q.landing_speed_threshold = i_cfg_data[THR_W-1:0];
                    REG_LANDING_CLIMB_THR: cfg_q.landing_climb_threshold = i_cfg_data[THR_W-1:0];
                    REG_LANDING_HOLD:      cfg_q.landing_hold_time       = i_cfg_data[TIME_W-1:0];
                    default: ;
                endcase
            end
            if (i_m_tvalid && i_m_tready) begin
                seen.phase            = t_phase'(i_m_tdata[1:0]);
                seen.phase_changed    = i_m_tdata[2];
                seen.phase_entry_time = i_m_tdata[34:3];
                seen.flight_duration  = i_m_tdata[66:35];
                if (reports_due.size() == 0) begin
                    $display("%0t unexpected result: expected none, got %h", $time, i_m_tdata);
                    mismatches++;
                end else begin
                    want = reports_due.pop_front();
                    if (seen.phase !== want.phase) begin
                        $display("%0t phase: expected %0d, got %0d", $time, want.phase, seen.phase);
                        mismatches++;
                    end
                    if (seen.phase_changed !== want.phase_changed) begin
                        $display("%0t phase_changed: expected %0b, got %0b",
                                 $time, want.phase_changed, seen.phase_changed);
                        mismatches++;
                    end
                    if (seen.phase_entry_time !== want.phase_entry_time) begin
                        $display("%0t phase_entry_time: expected %h, got %h",
                                 $time, want.phase_entry_time, seen.phase_entry_time);
                        mismatches++;
                    end
                    if (seen.flight_duration !== want.flight_duration) begin
                        $display("%0t flight_duration: expected %h, got %h",
                                 $time, want.flight_duration, seen.flight_duration);
                        mismatches++;
                    end
                end
            end
            if (i_s_tvalid && i_s_tready) begin
                step_phase_machine(i_s_tdata, want);
                reports_due.push_back(want);
            end
        end
        o_pending <= reports_due.size();
    end

endmodule

/* tb/tb_flight_phase_detector.sv */
// Testbench top for the flight phase detector: clock, reset, stimulus and verdict.
module tb_flight_phase_detector;
    import fpd_pkg::*;

    localparam logic [ADDR_W-1:0] REG_UNUSED6 = 3'd6;
    localparam logic [ADDR_W-1:0] REG_UNUSED7 = 3'd7;
    localparam int SPEED_MAX = 2**SPEED_W - 1;
    localparam int CLIMB_MAX = 2**(CLIMB_W-1) - 1;
    localparam int SESSIONS  = 6;
    localparam int PER_SESSION = 125;

    typedef enum int { SEG_QUIET, SEG_LAUNCH, SEG_LANDING, SEG_NOISE } t_seg;
    typedef enum int { CFG_RANDOM, CFG_ALL_LOW, CFG_ALL_HIGH } t_cfg_mode;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_s_axis_tvalid;
    logic              o_s_axis_tready;
    logic [63:0]       i_s_axis_tdata;
    logic              o_m_axis_tvalid;
    logic              i_m_axis_tready = 1'b0;
    logic [71:0]       o_m_axis_tdata;
    logic              i_cfg_valid;
    logic              o_cfg_ready;
    logic [ADDR_W-1:0] i_cfg_addr;
    logic [CFG_W-1:0]  i_cfg_data;

    int                errors;
    int                pending;
    int                src_idle_pct = 0;
    int                sink_idle_pct = 0;
    int                sink_hold = 0;
    t_seg              seg_mode = SEG_QUIET;
    int                seg_left = 0;
    logic [TIME_W-1:0] clock_ms;
    logic [THR_W-1:0]  lc_thr;
    logic [THR_W-1:0]  ls_thr;
    logic [THR_W-1:0]  ds_thr;
    logic [THR_W-1:0]  dc_thr;

    flight_phase_detector u_top (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .i_cfg_valid     (i_cfg_valid),
        .o_cfg_ready     (o_cfg_ready),
        .i_cfg_addr      (i_cfg_addr),
        .i_cfg_data      (i_cfg_data)
    );

    flight_phase_checker u_checker (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_s_tvalid  (i_s_axis_tvalid),
        .i_s_tready  (o_s_axis_tready),
        .i_s_tdata   (i_s_axis_tdata),
        .i_m_tvalid  (o_m_axis_tvalid),
        .i_m_tready  (i_m_axis_tready),
        .i_m_tdata   (o_m_axis_tdata),
        .i_cfg_valid (i_cfg_valid),
        .i_cfg_ready (o_cfg_ready),
        .i_cfg_addr  (i_cfg_addr),
        .i_cfg_data  (i_cfg_data),
        .o_errors    (errors),
        .o_pending   (pending)
    );

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    initial begin
        #2000000;
        $display("Regression FAIL");
        $finish;
    end

    // stall the result side in bursts of random length
    always @(posedge i_clk) begin
        if (sink_hold > 0) begin
            sink_hold <= sink_hold - 1;
            i_m_axis_tready <= 1'b0;
        end else if (sink_idle_pct > 0 && $urandom_range(0, 99) < sink_idle_pct) begin
            sink_hold <= $urandom_range(0, 10);
            i_m_axis_tready <= 1'b0;
        end else begin
            i_m_axis_tready <= 1'b1;
        end
    end

    task automatic write_reg(input logic [ADDR_W-1:0] idx, input logic [CFG_W-1:0] val);
        i_cfg_valid <= 1'b1;
        i_cfg_addr  <= idx;
        i_cfg_data  <= val;
        do @(posedge i_clk); while (!o_cfg_ready);
    endtask

    task automatic send_sample(input int climb, input int speed, input logic [TIME_W-1:0] ts);
        if (src_idle_pct > 0 && $urandom_range(0, 99) < src_idle_pct) begin
            i_s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {5'd0, ts, speed[SPEED_W-1:0], climb[CLIMB_W-1:0]};
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    task automatic drain();
        i_s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (pending != 0) @(posedge i_clk);
        repeat (4) @(posedge i_clk);
    endtask

    function automatic logic [THR_W-1:0] pick_threshold();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick == 2) return THR_W'($urandom);
        return THR_W'($urandom_range(0, 600));
    endfunction

    function automatic logic [TIME_W-1:0] pick_hold();
        int pick;
        pick = $urandom_range(0, 9);
        if (pick == 0) return '0;
        if (pick == 1) return '1;
        if (pick == 2) return $urandom;
        return $urandom_range(0, 4000);
    endfunction

    // upper bits beyond the register width are don't-care on the bus
    function automatic logic [CFG_W-1:0] pad_threshold(input logic [THR_W-1:0] thr);
        logic [CFG_W-1:0] v;
        v = ($urandom_range(0, 3) == 0) ? $urandom : '0;
        v[THR_W-1:0] = thr;
        return v;
    endfunction

    task automatic program_config(input t_cfg_mode mode);
        logic [TIME_W-1:0] launch_hold;
        logic [TIME_W-1:0] landing_hold;
        case (mode)
            CFG_ALL_LOW: begin
                lc_thr = '0; ls_thr = '0; ds_thr = '0; dc_thr = '0;
                launch_hold = '0; landing_hold = '0;
            end
            CFG_ALL_HIGH: begin
                lc_thr = '1; ls_thr = '1; ds_thr = '1; dc_thr = '1;
                launch_hold = '1; landing_hold = '1;
            end
            default: begin
                lc_thr = pick_threshold(); ls_thr = pick_threshold();
                ds_thr = pick_threshold(); dc_thr = pick_threshold();
                launch_hold = pick_hold(); landing_hold = pick_hold();
            end
        endcase
        write_reg(REG_LAUNCH_CLIMB_THR, pad_threshold(lc_thr));
        write_reg(REG_LAUNCH_SPEED_THR, pad_threshold(ls_thr));
        write_reg(REG_LAUNCH_HOLD, launch_hold);
        write_reg(REG_LANDING_SPEED_THR, pad_threshold(ds_thr));
        write_reg(REG_LANDING_CLIMB_THR, pad_threshold(dc_thr));
        write_reg(REG_LANDING_HOLD, landing_hold);
        if ($urandom_range(0, 1)) write_reg($urandom_range(0, 1) ? REG_UNUSED6 : REG_UNUSED7, $urandom);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
    endtask

    // runs of samples that push the phase machine toward launch or landing, keep it quiet, or are random noise
    task automatic send_shaped();
        int climb;
        int speed;
        int mag;
        int pick;
        if (seg_left == 0) begin
            pick = $urandom_range(0, 99);
            seg_mode = (pick < 35) ? SEG_LAUNCH : (pick < 70) ? SEG_LANDING :
                       (pick < 85) ? SEG_QUIET : SEG_NOISE;
            seg_left = $urandom_range(1, 10);
        end
        seg_left--;
        climb = $urandom;
        speed = $urandom;
        case (seg_mode)
            SEG_LAUNCH: begin
                if ($urandom_range(0, 1)) speed = $urandom_range(ls_thr, SPEED_MAX);
                else climb = $urandom_range(lc_thr, CLIMB_MAX);
            end
            SEG_LANDING: begin
                speed = $urandom_range(0, ds_thr);
                mag = $urandom_range(0, dc_thr);
                if (mag > CLIMB_MAX) mag = CLIMB_MAX;
                climb = $urandom_range(0, 1) ? mag : -mag;
            end
            SEG_QUIET: begin
                speed = $urandom_range(0, ls_thr);
                climb = -$urandom_range(0, CLIMB_MAX + 1);
            end
            default: ;
        endcase
        pick = $urandom_range(0, 99);
        if (pick < 85) clock_ms = clock_ms + $urandom_range(0, 1500);
        else if (pick < 90) clock_ms = clock_ms + $urandom;
        else if (pick < 95) clock_ms = clock_ms - 1;
        send_sample(climb, speed, clock_ms);
    endtask

    initial begin
        i_rst_n         <= 1'b0;
        i_s_axis_tvalid <= 1'b0;
        i_s_axis_tdata  <= '0;
        i_cfg_valid     <= 1'b0;
        i_cfg_addr      <= '0;
        i_cfg_data      <= '0;
        repeat (8) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        src_idle_pct  = 20;
        sink_idle_pct = 20;
        // default thresholds: qualify, clear, restart, launch, fly, land
        send_sample(0, 0, 32'd0);
        send_sample(CLIMB_MAX, 0, 32'd100);
        send_sample(-CLIMB_MAX - 1, SPEED_MAX, 32'd200);
        send_sample(0, 0, 32'd300);
        send_sample(0, 101, 32'd1000);
        send_sample(0, 101, 32'd6000);
        send_sample(0, 0, 32'd6500);
        send_sample(0, 0, 32'd7000);
        send_sample(29, 29, 32'd20000);
        send_sample(-29, 0, 32'd67000);
        send_sample(0, 0, 32'd67100);
        drain();

        // zero hold times, flight starting at time zero, ignored register slots
        write_reg(REG_LAUNCH_HOLD, '0);
        write_reg(REG_LANDING_HOLD, '0);
        write_reg(REG_UNUSED6, '1);
        write_reg(REG_UNUSED7, '1);
        i_cfg_valid <= 1'b0;
        @(posedge i_clk);
        send_sample(0, SPEED_MAX, 32'hFFFF_FFFF);
        send_sample(0, 0, 32'd0);
        send_sample(CLIMB_MAX, 0, 32'd5);
        send_sample(-30, 0, 32'd10);
        send_sample(0, 0, 32'd20);
        send_sample(0, 0, 32'd30);
        drain();

        lc_thr   = RST_LAUNCH_CLIMB_THR;
        clock_ms = 32'd40;
        for (int s = 0; s < SESSIONS; s++) begin
            case (s)
                1:       program_config(CFG_ALL_LOW);
                3:       program_config(CFG_ALL_HIGH);
                default: program_config(CFG_RANDOM);
            endcase
            if (s == SESSIONS - 1) begin
                src_idle_pct  = 0;
                sink_idle_pct = 0;
            end else begin
                src_idle_pct  = $urandom_range(0, 30);
                sink_idle_pct = $urandom_range(0, 30);
            end
            for (int n = 0; n < PER_SESSION; n++) send_shaped();
            drain();
        end

        if (errors == 0 && pending == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
